// ===== hw/rtl/dlfb_pkg.sv =====
package dlfb_pkg;

  // Default geometry
  localparam int LAYER_BYTES_DEF = 131072;
  localparam int LINE_PITCH_DEF  = 512;

  // Byte lanes in one memory row
  localparam int LANES = 4;

  // Item commands
  typedef enum logic [1:0] {
    MODE_WR_BACK  = 2'd0,
    MODE_WR_FRONT = 2'd1,
    MODE_BANK     = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  // Access size codes; any other code is a word access
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Layer 1 byte value that leaves the stored byte unchanged
  localparam logic [7:0] TRANSPARENT_BYTE = 8'hff;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;   // write zero to the clear row, advance the row counter
    logic wr_back;    // layer 0 write
    logic wr_front;   // layer 1 transparent write
    logic set_bank;   // load the write bank
    logic load_zero;  // result register takes zero
    logic load_pixel; // result register takes the composited pixel
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last; // clear row counter sits on the last row
  } status_t;

endpackage

// ===== hw/rtl/dlfb_lane_ram.sv =====
module dlfb_lane_ram #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dlfb_dp.sv =====
module dlfb_dp #(
  parameter int LAYER_BYTES = dlfb_pkg::LAYER_BYTES_DEF,
  parameter int LINE_PITCH  = dlfb_pkg::LINE_PITCH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dlfb_pkg::cmd_t   cmd,
  output dlfb_pkg::status_t status,
  input  logic [16:0]      in_offset,
  input  logic [1:0]       in_access_size,
  input  logic [31:0]      in_write_data,
  input  logic             in_bank_select,
  input  logic [8:0]       in_pixel_x,
  input  logic [7:0]       in_pixel_y,
  output logic [8:0]       out_palette_index
);

  // Byte address bits within one bank, row index bits over both banks
  localparam int AW    = $clog2(LAYER_BYTES);
  localparam int ROW_W = AW - 1;
  localparam int LANES = dlfb_pkg::LANES;

  logic             write_bank_r;
  logic [ROW_W-1:0] clr_row_r;
  logic [ROW_W-1:0] clr_row_nxt;
  logic [1:0]       rd_lane_r;
  logic [8:0]       palette_index_r;
  logic [8:0]       palette_index_nxt;

  logic [31:0]      off_ext;
  logic [AW-1:0]    wr_addr;
  logic [31:0]      pix_lin;
  logic [AW-1:0]    pix_addr;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] ram_waddr;

  logic [LANES-1:0] lane_hit;
  logic [7:0]       lane_byte [LANES];
  logic [LANES-1:0] back_we;
  logic [LANES-1:0] front_we;
  logic [7:0]       back_wdata [LANES];
  logic [7:0]       front_wdata [LANES];
  logic [7:0]       back_rdata [LANES];
  logic [7:0]       front_rdata [LANES];
  logic [7:0]       top_byte;
  logic [7:0]       under_byte;

  // Byte addresses wrap modulo the bank size
  assign off_ext  = {15'd0, in_offset};
  assign wr_addr  = off_ext[AW-1:0];
  assign pix_lin  = 32'(in_pixel_y) * 32'(LINE_PITCH) + 32'(in_pixel_x);
  assign pix_addr = pix_lin[AW-1:0];

  // Writes go to the selected bank, scanout reads the other one
  assign wr_row    = {write_bank_r, wr_addr[AW-1:2]};
  assign rd_row    = {~write_bank_r, pix_addr[AW-1:2]};
  assign ram_waddr = cmd.clear_wr ? clr_row_r : wr_row;

  // Steer big-endian write bytes onto their lanes
  always_comb begin
    int i;
    lane_hit = '0;
    for (i = 0; i < LANES; i++) begin
      lane_byte[i] = 8'd0;
    end
    case (in_access_size)
      dlfb_pkg::SIZE_BYTE: begin
        lane_hit[wr_addr[1:0]]  = 1'b1;
        lane_byte[wr_addr[1:0]] = in_write_data[7:0];
      end
      dlfb_pkg::SIZE_HALF: begin
        lane_hit[{wr_addr[1], 1'b0}]  = 1'b1;
        lane_hit[{wr_addr[1], 1'b1}]  = 1'b1;
        lane_byte[{wr_addr[1], 1'b0}] = in_write_data[15:8];
        lane_byte[{wr_addr[1], 1'b1}] = in_write_data[7:0];
      end
      default: begin
        for (i = 0; i < LANES; i++) begin
          lane_hit[i]  = 1'b1;
          lane_byte[i] = in_write_data[8*(LANES-1-i) +: 8];
        end
      end
    endcase
  end

  // Lane enables: clear writes zero everywhere, layer 1 drops transparent bytes
  always_comb begin
    int i;
    for (i = 0; i < LANES; i++) begin
      back_we[i]     = cmd.clear_wr | (cmd.wr_back & lane_hit[i]);
      front_we[i]    = cmd.clear_wr |
                       (cmd.wr_front & lane_hit[i] &
                        (lane_byte[i] != dlfb_pkg::TRANSPARENT_BYTE));
      back_wdata[i]  = cmd.clear_wr ? 8'd0 : lane_byte[i];
      front_wdata[i] = cmd.clear_wr ? 8'd0 : lane_byte[i];
    end
  end

  // Lane memories for both layers
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    dlfb_lane_ram #(.ADDR_W(ROW_W)) u_back (
      .clk   (clk),
      .we    (back_we[g]),
      .waddr (ram_waddr),
      .wdata (back_wdata[g]),
      .raddr (rd_row),
      .rdata (back_rdata[g])
    );
    dlfb_lane_ram #(.ADDR_W(ROW_W)) u_front (
      .clk   (clk),
      .we    (front_we[g]),
      .waddr (ram_waddr),
      .wdata (front_wdata[g]),
      .raddr (rd_row),
      .rdata (front_rdata[g])
    );
  end

  // Advance the clear row counter
  assign clr_row_nxt       = cmd.clear_wr ? clr_row_r + ROW_W'(1) : clr_row_r;
  assign status.clear_last = &clr_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_bank_r <= 1'b0;
      clr_row_r    <= '0;
    end else begin
      clr_row_r <= clr_row_nxt;
      if (cmd.set_bank) begin
        write_bank_r <= in_bank_select;
      end
    end
  end

  // Hold the lane of a scanout read until its data arrives
  always_ff @(posedge clk) begin
    rd_lane_r <= pix_addr[1:0];
  end

  // Composite: layer 1 wins when nonzero, else layer 0 with the high palette bit
  assign top_byte   = front_rdata[rd_lane_r];
  assign under_byte = back_rdata[rd_lane_r];

  always_comb begin
    palette_index_nxt = palette_index_r;
    if (cmd.load_zero) begin
      palette_index_nxt = 9'd0;
    end else if (cmd.load_pixel) begin
      palette_index_nxt = (top_byte != 8'd0) ? {1'b0, top_byte} : {1'b1, under_byte};
    end
  end

  always_ff @(posedge clk) begin
    palette_index_r <= palette_index_nxt;
  end

  assign out_palette_index = palette_index_r;

endmodule

// ===== hw/rtl/dlfb_ctrl.sv =====
module dlfb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  output logic              out_valid,
  input  logic              out_stall,
  output dlfb_pkg::cmd_t    cmd,
  input  dlfb_pkg::status_t status
);

  dlfb_pkg::state_t state_r;
  dlfb_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             in_xfer;
  logic             out_xfer;
  logic             slot_free;

  assign out_xfer  = out_valid_r & ~out_stall;
  assign slot_free = ~out_valid_r | ~out_stall;
  assign in_stall  = ~((state_r == dlfb_pkg::ST_IDLE) & slot_free);
  assign in_xfer   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlfb_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_xfer;
    case (state_r)
      dlfb_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_nxt = dlfb_pkg::ST_IDLE;
        end
      end
      dlfb_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (dlfb_pkg::mode_t'(in_mode))
            dlfb_pkg::MODE_WR_BACK: begin
              cmd.wr_back   = 1'b1;
              cmd.load_zero = 1'b1;
              out_valid_nxt = 1'b1;
            end
            dlfb_pkg::MODE_WR_FRONT: begin
              cmd.wr_front  = 1'b1;
              cmd.load_zero = 1'b1;
              out_valid_nxt = 1'b1;
            end
            dlfb_pkg::MODE_BANK: begin
              cmd.set_bank  = 1'b1;
              cmd.load_zero = 1'b1;
              out_valid_nxt = 1'b1;
            end
            default: begin
              // Scanout read: memory data comes back next cycle
              state_nxt = dlfb_pkg::ST_READ;
            end
          endcase
        end
      end
      dlfb_pkg::ST_READ: begin
        cmd.load_pixel = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = dlfb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dlfb_pkg::ST_IDLE;
      end
    endcase
  end

  // No transfer is taken while memory is being cleared
  a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dlfb_pkg::ST_CLEAR) |-> in_stall)
    else $error("input transfer during memory clear");

  // A scanout read presents its result once the ST_READ state has loaded the result register
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_mode == dlfb_pkg::MODE_READ) |-> ##2 out_valid_r)
    else $error("scanout result missing");

  // Writes and bank commands present their result in the next cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_mode != dlfb_pkg::MODE_READ) |=> out_valid_r)
    else $error("write result missing");

  // Only one memory operation per cycle
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_wr, cmd.wr_back, cmd.wr_front, cmd.set_bank, cmd.load_pixel}))
    else $error("conflicting datapath commands");

endmodule

// ===== hw/rtl/dual_layer_framebuffer_transparent_write.sv =====
// Two-layer, double-buffered byte-per-pixel framebuffer. After reset the block
// sweeps all memory to zero, one 4-byte row of both layers per clock, with the
// row counter running over both banks; in_stall stays high until the sweep
// ends. Then layer writes and bank commands transfer back to back while no
// stalled result waits; a scanout read goes through the registered read port
// of the lane memories and the read state, and no input is taken until it is
// done. Each item returns one result on the out_ channel (zero except for
// scanout reads); a waiting result does not block the next input as long as
// out_stall is low. LAYER_BYTES must be a power of two.
module dual_layer_framebuffer_transparent_write #(
  parameter int LAYER_BYTES = dlfb_pkg::LAYER_BYTES_DEF,
  parameter int LINE_PITCH  = dlfb_pkg::LINE_PITCH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [16:0] in_offset,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_write_data,
  input  logic        in_bank_select,
  input  logic [8:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_palette_index
);

  dlfb_pkg::cmd_t    cmd;
  dlfb_pkg::status_t status;

  dlfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  dlfb_dp #(
    .LAYER_BYTES (LAYER_BYTES),
    .LINE_PITCH  (LINE_PITCH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_offset         (in_offset),
    .in_access_size    (in_access_size),
    .in_write_data     (in_write_data),
    .in_bank_select    (in_bank_select),
    .in_pixel_x        (in_pixel_x),
    .in_pixel_y        (in_pixel_y),
    .out_palette_index (out_palette_index)
  );

endmodule

// ===== sim/tb_dual_layer_framebuffer_transparent_write.sv =====
`timescale 1ns / 100ps

module tb_dual_layer_framebuffer_transparent_write;

  localparam int BANK_BYTES   = dlfb_pkg::LAYER_BYTES_DEF;
  localparam int PITCH        = dlfb_pkg::LINE_PITCH_DEF;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CALM_ITEMS   = 300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PREDICT      = -1;

  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_ODD  = 2'd3;

  typedef struct packed {
    dlfb_pkg::mode_t mode;
    logic [16:0]     offset;
    logic [1:0]      size;
    logic [31:0]     data;
    logic            bank;
    logic [8:0]      px;
    logic [7:0]      py;
  } pixel_op_t;

  // want < 0: take the index from the framebuffer model
  typedef struct packed {
    pixel_op_t op;
    int        want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = 2'd0;
  logic [16:0] in_offset = '0;
  logic [1:0]  in_access_size = 2'd0;
  logic [31:0] in_write_data = '0;
  logic        in_bank_select = 1'b0;
  logic [8:0]  in_pixel_x = '0;
  logic [7:0]  in_pixel_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  out_palette_index;

  // Framebuffer model: both banks of both layers, cleared like the block
  bit [7:0]   back_mem [2*BANK_BYTES];
  bit [7:0]   front_mem [2*BANK_BYTES];
  bit         wr_bank = 1'b0;

  logic [8:0] palette_q [$];
  logic [7:0] hot_rows [4];
  int         mismatches = 0;
  int         cycles = 0;
  bit         calm = 1'b0;
  int         send_quiet = 0;
  int         stall_left = 0;
  int         stall_quiet = 0;
  int         stall_roll;

  dual_layer_framebuffer_transparent_write i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_offset        (in_offset),
    .in_access_size   (in_access_size),
    .in_write_data    (in_write_data),
    .in_bank_select   (in_bank_select),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_palette_index(out_palette_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int mem_index(bit bank, int addr);
    return int'(bank) * BANK_BYTES + (addr % BANK_BYTES);
  endfunction

  // Apply one transfer to the model and return the palette index it yields
  function automatic logic [8:0] composite_step(pixel_op_t op);
    int         nbytes;
    int         base;
    int         idx;
    int         i;
    logic [7:0] lane;
    logic [8:0] index;
    index = '0;
    case (op.mode)
      dlfb_pkg::MODE_WR_BACK, dlfb_pkg::MODE_WR_FRONT: begin
        if (op.size == dlfb_pkg::SIZE_BYTE) nbytes = 1;
        else if (op.size == dlfb_pkg::SIZE_HALF) nbytes = 2;
        else nbytes = 4;
        // round down to the access size, most significant byte first
        base = int'(op.offset) & ~(nbytes - 1);
        for (i = 0; i < nbytes; i++) begin
          lane = op.data[8*(nbytes-1-i) +: 8];
          idx = mem_index(wr_bank, base + i);
          if (op.mode == dlfb_pkg::MODE_WR_BACK) back_mem[idx] = lane;
          else if (lane != dlfb_pkg::TRANSPARENT_BYTE) front_mem[idx] = lane;
        end
      end
      dlfb_pkg::MODE_BANK: wr_bank = op.bank;
      default: begin
        // scan out of the bank that is not being written
        idx = mem_index(~wr_bank, int'(op.py) * PITCH + int'(op.px));
        if (front_mem[idx] != 8'h00) index = {1'b0, front_mem[idx]};
        else index = {1'b1, back_mem[idx]};
      end
    endcase
    return index;
  endfunction

  function automatic pixel_op_t noise_op();
    pixel_op_t op;
    op.mode   = dlfb_pkg::mode_t'($urandom_range(0, 3));
    op.offset = 17'($urandom);
    op.size   = 2'($urandom_range(0, 3));
    op.data   = $urandom;
    op.bank   = 1'($urandom_range(0, 1));
    op.px     = 9'($urandom);
    op.py     = 8'($urandom);
    return op;
  endfunction

  function automatic script_row_t rd_row(int x, int y, int want);
    script_row_t r;
    r.op      = noise_op();
    r.op.mode = dlfb_pkg::MODE_READ;
    r.op.px   = 9'(x);
    r.op.py   = 8'(y);
    r.want    = want;
    return r;
  endfunction

  function automatic script_row_t wr_row(dlfb_pkg::mode_t mode, int offset,
                                         logic [1:0] size, logic [31:0] data);
    script_row_t r;
    r.op        = noise_op();
    r.op.mode   = mode;
    r.op.offset = 17'(offset);
    r.op.size   = size;
    r.op.data   = data;
    r.want      = 0;
    return r;
  endfunction

  function automatic script_row_t sel_row(bit bank);
    script_row_t r;
    r.op      = noise_op();
    r.op.mode = dlfb_pkg::MODE_BANK;
    r.op.bank = bank;
    r.want    = 0;
    return r;
  endfunction

  function automatic pixel_op_t random_op();
    pixel_op_t  op;
    int         pick;
    int         i;
    logic [7:0] row;
    logic [8:0] col;
    op = noise_op();
    pick = $urandom_range(0, 99);
    if (pick < 28) op.mode = dlfb_pkg::MODE_WR_BACK;
    else if (pick < 58) op.mode = dlfb_pkg::MODE_WR_FRONT;
    else if (pick < 66) op.mode = dlfb_pkg::MODE_BANK;
    else op.mode = dlfb_pkg::MODE_READ;
    // Aim most transfers at a few short pixel runs so reads hit written bytes
    if ($urandom_range(0, 9) < 8) begin
      row = hot_rows[$urandom_range(0, 3)];
      col = $urandom_range(0, 1) ? 9'($urandom_range(0, 15)) : 9'($urandom_range(496, 511));
      op.offset = {row, col};
      op.py = row;
      op.px = col;
    end
    // Favor zero and transparent lanes
    if ($urandom_range(0, 4) != 0) begin
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0: op.data[8*i +: 8] = 8'h00;
          1: op.data[8*i +: 8] = dlfb_pkg::TRANSPARENT_BYTE;
          default: ;
        endcase
      end
    end
    return op;
  endfunction

  // Drive one transfer, hold it until accepted, then queue its expected index
  task automatic send_op(input pixel_op_t op, input int want);
    logic [8:0] predicted;
    if (!calm && send_quiet == 0 && $urandom_range(0, 49) == 0)
      send_quiet = $urandom_range(30, 120);
    if (send_quiet > 0) begin
      send_quiet--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= op.mode;
    in_offset      <= op.offset;
    in_access_size <= op.size;
    in_write_data  <= op.data;
    in_bank_select <= op.bank;
    in_pixel_x     <= op.px;
    in_pixel_y     <= op.py;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = composite_step(op);
    palette_q.push_back(want < 0 ? predicted : 9'(want));
  endtask

  // Stall the result channel in random bursts, with quiet stretches
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_quiet > 0) begin
      out_stall <= 1'b0;
      stall_quiet--;
    end else begin
      stall_roll = $urandom_range(0, 19);
      if (stall_roll < 4) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 7);
      end else begin
        if (stall_roll == 4) stall_quiet = $urandom_range(20, 100);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expected index
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (palette_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result transfer: palette_index=%h", out_palette_index);
        mismatches++;
      end else if (out_palette_index !== palette_q[0]) begin
        if (mismatches < 10)
          $display("palette_index mismatch: expected %h, got %h",
                   palette_q[0], out_palette_index);
        mismatches++;
        void'(palette_q.pop_front());
      end else begin
        void'(palette_q.pop_front());
      end
    end
  end

  // Bound the run, the clearing sweep after reset included
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    script_row_t script [$];
    int          n;

    hot_rows[0] = 8'd0;
    hot_rows[1] = 8'd255;
    hot_rows[2] = 8'($urandom_range(1, 254));
    hot_rows[3] = 8'($urandom_range(1, 254));

    // Directed: scan out after reset, extremes, transparency, alignment, banking
    script.push_back(rd_row(0, 0, 'h100));
    script.push_back(rd_row(511, 255, 'h100));
    script.push_back(wr_row(dlfb_pkg::MODE_WR_BACK, 0, SIZE_WORD, 32'hffffffff));
    script.push_back(wr_row(dlfb_pkg::MODE_WR_FRONT, 0, SIZE_WORD, 32'h12ff00ff));
    script.push_back(sel_row(1'b1));
    script.push_back(rd_row(0, 0, 'h012));
    script.push_back(rd_row(1, 0, 'h1ff));
    script.push_back(rd_row(2, 0, PREDICT));
    script.push_back(rd_row(3, 0, PREDICT));
    script.push_back(wr_row(dlfb_pkg::MODE_WR_FRONT, 5, dlfb_pkg::SIZE_HALF, 32'h1234abcd));
    script.push_back(wr_row(dlfb_pkg::MODE_WR_BACK, 'h1ffff, SIZE_ODD, 32'h01020304));
    script.push_back(wr_row(dlfb_pkg::MODE_WR_FRONT, 'h1fffe, dlfb_pkg::SIZE_BYTE,
                            32'h000000ff));
    script.push_back(wr_row(dlfb_pkg::MODE_WR_FRONT, 'h1ffff, dlfb_pkg::SIZE_BYTE,
                            32'hffffff80));
    script.push_back(wr_row(dlfb_pkg::MODE_WR_FRONT, 4, SIZE_WORD, 32'hffffffff));
    script.push_back(wr_row(dlfb_pkg::MODE_WR_BACK, 'h10000, dlfb_pkg::SIZE_HALF,
                            32'h0000ffff));
    script.push_back(sel_row(1'b0));
    script.push_back(rd_row(4, 0, PREDICT));
    script.push_back(rd_row(5, 0, PREDICT));
    script.push_back(rd_row(508, 255, PREDICT));
    script.push_back(rd_row(510, 255, PREDICT));
    script.push_back(rd_row(511, 255, 'h080));
    script.push_back(rd_row(0, 0, 'h100));
    script.push_back(rd_row(0, 128, PREDICT));
    script.push_back(sel_row(1'b1));
    script.push_back(rd_row(3, 0, PREDICT));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) send_op(script[k].op, script[k].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      // hold off once until every queued result has drained
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (palette_q.size() != 0) @(posedge clk);
      end
      send_op(random_op(), PREDICT);
    end
    in_valid <= 1'b0;

    while (palette_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
